[hdl/nq_pkg.sv]
package nq_pkg;

  // Fixed field widths of the item channels and the size register
  localparam int BoardW    = 4;
  localparam int PlaceW    = 24;
  localparam int CountW    = 8;
  localparam int ColShownW = 3;
  localparam int RowsShown = 8;

  localparam logic [BoardW-1:0] BoardReset = 4'd8;
  localparam logic [CountW-1:0] CountMax   = 8'hFF;

  // Command that the controller hands to each cell
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INC,
    OP_ZERO,
    OP_CLEAR
  } cell_op_e;

  // Search controller states
  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } ctrl_state_e;

endpackage

[hdl/nq_if.sv]
interface nq_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface nq_rsp_if;
  import nq_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [PlaceW-1:0] placement;
  logic [CountW-1:0] solutions_so_far;

  modport source (output valid, output found, output placement, output solutions_so_far,
                  input ready);
  modport sink (input valid, input found, input placement, input solutions_so_far,
                output ready);
endinterface

[hdl/n_queens_solution_generator.sv]
// N-queens solution generator.
// Request channel req_i carries one bit, restart: 1 clears the board and the
// solution count and looks for the first placement, 0 looks for the next one.
// Each request gives exactly one item on rsp_o: found, the packed column of
// every row (3 bits per row, row 0 lowest, zero when found is 0) and the
// saturating count of solutions since the last restart.
// The board size register is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while the block is idle, which the block itself does not
// enforce. A write in idle also restarts the search. A request is taken while
// idle; the search then runs one placement trial or backtrack step at a time,
// and the output register loads at the end of the last step. A trial is one
// pass through the row of cells, which compare the candidate column against
// every placed queen and ripple a conflict flag along the chain. A request
// after exhaustion makes no trial and reports exhaustion again.
// One request is searched at a time; ready is high while no search runs,
// even when a result still waits in the output register.
// When rsp_o is stalled, a finished search holds at its last step until the
// output register frees up. Reset sets the board size to 8 and clears the
// board, row pointer, exhausted flag and count.
module n_queens_solution_generator #(
  parameter int MAX_N = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  nq_req_if.sink                      req_i,
  nq_rsp_if.source                    rsp_o,
  input  logic                        cfg_we_i,
  input  logic [nq_pkg::BoardW-1:0]   cfg_wdata_i
);
  import nq_pkg::*;

  localparam int CW    = $clog2(MAX_N + 1);
  localparam int RW    = $clog2(MAX_N);
  localparam int Shown = (MAX_N < RowsShown) ? MAX_N : RowsShown;
  localparam logic [4:0] MaxN5 = 5'(MAX_N);

  ctrl_state_e       state_q, state_d;
  logic [BoardW-1:0] board_q;
  logic [RW-1:0]     k_q, k_d;
  logic              exh_q, exh_d;
  logic [CountW-1:0] cnt_q, cnt_d;

  logic [CW-1:0]     cols [MAX_N];
  cell_op_e          cell_op [MAX_N];
  logic [MAX_N:0]    conf;

  logic [4:0]        n_wide;
  logic [CW-1:0]     n_act;
  logic [CW-1:0]     cand;
  logic [CW-1:0]     k_ext;
  logic              safe;
  logic              req_acc;
  logic              out_free;

  logic              clear_all;
  logic [RW-1:0]     tgt;
  cell_op_e          tgt_op;
  logic              load_out;
  logic              load_found;

  logic              out_valid_q;
  logic              out_found_q;
  logic [PlaceW-1:0] out_place_q;
  logic [CountW-1:0] out_cnt_q;
  logic [PlaceW-1:0] place;

  // Active board size, capped at the built maximum
  assign n_wide = ({1'b0, board_q} > MaxN5) ? MaxN5 : {1'b0, board_q};
  assign n_act  = CW'(n_wide);

  assign cand     = cols[k_q];
  assign k_ext    = CW'(k_q);
  assign safe     = !conf[MAX_N];
  assign req_acc  = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == ST_IDLE);

  // Row of cells, one per board row
  assign conf[0] = 1'b0;
  for (genvar r = 0; r < MAX_N; r++) begin : g_cell
    nq_cell #(
      .MAX_N (MAX_N),
      .ROW   (r)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .op_i       (cell_op[r]),
      .cand_col_i (cand),
      .cand_row_i (k_q),
      .conf_i     (conf[r]),
      .conf_o     (conf[r+1]),
      .col_o      (cols[r])
    );
  end

  // Steer the controller command to the target row
  always_comb begin
    for (int r = 0; r < MAX_N; r++) begin
      if (clear_all) begin
        cell_op[r] = OP_CLEAR;
      end else if (RW'(r) == tgt) begin
        cell_op[r] = tgt_op;
      end else begin
        cell_op[r] = OP_HOLD;
      end
    end
  end

  // Search sequencer: one trial or backtrack step per cycle, holding at the last step while the output register is full
  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    exh_d      = exh_q;
    cnt_d      = cnt_q;
    clear_all  = 1'b0;
    tgt        = k_q;
    tgt_op     = OP_HOLD;
    load_out   = 1'b0;
    load_found = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          clear_all = 1'b1;
          k_d       = '0;
          exh_d     = 1'b0;
          cnt_d     = '0;
        end else if (req_acc) begin
          if (req_i.restart) begin
            clear_all = 1'b1;
            k_d       = '0;
            exh_d     = 1'b0;
            cnt_d     = '0;
          end
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (exh_q || (n_act == '0)) begin
          // report exhaustion
          if (out_free) begin
            exh_d    = 1'b1;
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end
        end else if (cand >= n_act) begin
          if (k_q == '0) begin
            if (out_free) begin
              exh_d    = 1'b1;
              k_d      = '0;
              load_out = 1'b1;
              state_d  = ST_IDLE;
            end
          end else begin
            // backtrack and advance the row above
            k_d    = k_q - RW'(1);
            tgt    = k_q - RW'(1);
            tgt_op = OP_INC;
          end
        end else if (safe) begin
          if ((k_ext + CW'(1)) >= n_act) begin
            // full placement: report it and step past it
            if (out_free) begin
              load_out   = 1'b1;
              load_found = 1'b1;
              cnt_d      = (cnt_q != CountMax) ? (cnt_q + CountW'(1)) : cnt_q;
              tgt_op     = OP_INC;
              state_d    = ST_IDLE;
            end
          end else begin
            k_d    = k_q + RW'(1);
            tgt    = k_q + RW'(1);
            tgt_op = OP_ZERO;
          end
        end else begin
          tgt_op = OP_INC;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      board_q <= BoardReset;
      k_q     <= '0;
      exh_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      exh_q   <= exh_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        board_q <= cfg_wdata_i;
      end
    end
  end

  // Pack the shown rows of the current board
  always_comb begin
    place = '0;
    for (int r = 0; r < Shown; r++) begin
      if (CW'(r) < n_act) begin
        place[ColShownW*r +: ColShownW] = cols[r][ColShownW-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_found_q <= load_found;
      out_place_q <= load_found ? place : '0;
      out_cnt_q   <= cnt_d;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.found            = out_found_q;
  assign rsp_o.placement        = out_place_q;
  assign rsp_o.solutions_so_far = out_cnt_q;

  // Checks
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || rsp_o.ready))
    else $error("result loaded over a waiting item");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH && !exh_q && n_act != '0) |-> (k_ext < n_act))
    else $error("search row beyond board size");

  a_empty_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.found) |-> (rsp_o.placement == '0))
    else $error("placement not zero on exhausted result");

  a_count_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.found) |-> (rsp_o.solutions_so_far != '0))
    else $error("solution reported with zero count");

endmodule

[hdl/nq_cell.sv]
module nq_cell #(
  parameter int MAX_N = 8,
  parameter int ROW   = 0,
  localparam int CW = $clog2(MAX_N + 1),
  localparam int RW = $clog2(MAX_N)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nq_pkg::cell_op_e  op_i,
  input  logic [CW-1:0]     cand_col_i,
  input  logic [RW-1:0]     cand_row_i,
  input  logic              conf_i,
  output logic              conf_o,
  output logic [CW-1:0]     col_o
);
  import nq_pkg::*;

  localparam logic [CW-1:0] RowC = CW'(ROW);

  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] cand_row;
  logic [CW-1:0] diff;
  logic [CW-1:0] row_gap;
  logic          above;

  // Update the column held for this row
  always_comb begin
    case (op_i)
      OP_HOLD:  col_d = col_q;
      OP_INC:   col_d = col_q + CW'(1);
      OP_ZERO:  col_d = '0;
      OP_CLEAR: col_d = '0;
      default:  col_d = col_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  // Check the candidate against this row's queen; pass the flag down the chain
  assign cand_row = CW'(cand_row_i);
  assign above    = cand_row > RowC;
  assign diff     = (cand_col_i > col_q) ? (cand_col_i - col_q) : (col_q - cand_col_i);
  assign row_gap  = cand_row - RowC;
  assign conf_o   = conf_i | (above && ((col_q == cand_col_i) || (diff == row_gap)));
  assign col_o    = col_q;

endmodule

[tb/n_queens_solution_generator_tb.sv]
`timescale 1ns / 100ps

module n_queens_solution_generator_tb;
  import nq_pkg::*;

  localparam int MaxN           = 8;
  localparam int LongHoldCycles = 300;
  localparam int RandomItems    = 260;
  localparam int QuietItems     = 60;
  localparam int MaxPrinted     = 40;

  // One result item as the block should give it
  typedef struct {
    logic              found;
    logic [PlaceW-1:0] placement;
    logic [CountW-1:0] solutions;
  } queens_result_t;

  logic clk;
  logic rst_ni;
  logic cfg_we;
  logic [BoardW-1:0] cfg_wdata;

  nq_req_if req_ch ();
  nq_rsp_if rsp_ch ();

  n_queens_solution_generator #(
    .MAX_N(MaxN)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // Search state of the predictor
  logic [BoardW-1:0] model_size;
  logic [3:0]        model_cols [MaxN];
  logic [3:0]        model_row;
  logic              model_exhausted;
  logic [CountW-1:0] model_count;

  queens_result_t awaited_results[$];

  int unsigned mismatch_count    = 0;
  int unsigned items_sent        = 0;
  int unsigned settings_written  = 0;
  int unsigned placements_seen   = 0;
  int unsigned exhausted_seen    = 0;
  bit          gaps_on           = 1'b1;
  bit          stalls_on         = 1'b1;
  bit          long_hold_req     = 1'b0;

  // Free-running clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Clear board, row pointer, exhausted flag and count
  function automatic void clear_board_model();
    int r;
    for (r = 0; r < MaxN; r++) model_cols[r] = '0;
    model_row       = '0;
    model_exhausted = 1'b0;
    model_count     = '0;
  endfunction

  function automatic int board_rows();
    return (model_size > MaxN) ? MaxN : int'(model_size);
  endfunction

  // Check the queen of row k against every queen above it
  function automatic bit row_has_no_conflict(input int k);
    int r;
    int c;
    int o;
    int d;
    c = model_cols[k];
    for (r = 0; r < k; r++) begin
      o = model_cols[r];
      d = (c > o) ? c - o : o - c;
      if (o == c || d == k - r) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Backtrack until the next full placement or until the tree is used up
  function automatic bit advance_to_solution();
    int n;
    int k;
    n = board_rows();
    k = model_row;
    if (model_exhausted) return 1'b0;
    if (n == 0 || k >= n) begin
      model_exhausted = 1'b1;
      return 1'b0;
    end
    while (1) begin
      if (model_cols[k] >= n) begin
        if (k == 0) begin
          model_exhausted = 1'b1;
          model_row       = '0;
          return 1'b0;
        end
        k--;
        model_cols[k]++;
      end else if (row_has_no_conflict(k)) begin
        if (k + 1 >= n) begin
          model_row = 4'(k);
          return 1'b1;
        end
        k++;
        model_cols[k] = '0;
      end else begin
        model_cols[k]++;
      end
    end
    return 1'b0;
  endfunction

  // Work out the result of one accepted request and queue it
  function automatic void predict_queens_result(input bit restart);
    queens_result_t want;
    int r;
    int n;
    if (restart) clear_board_model();
    want.found     = 1'b0;
    want.placement = '0;
    if (advance_to_solution()) begin
      n = board_rows();
      want.found = 1'b1;
      for (r = 0; r < n && r < RowsShown; r++) begin
        want.placement[ColShownW*r +: ColShownW] = model_cols[r][ColShownW-1:0];
      end
      if (model_count != CountMax) model_count++;
      // resume with the next column of the last row
      model_cols[model_row]++;
    end
    want.solutions = model_count;
    awaited_results.push_back(want);
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    end
  endtask

  // Offer one request item, with an optional idle burst first
  task automatic send_request(input bit restart);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.restart <= restart;
    do @(posedge clk); while (!req_ch.ready);
    predict_queens_result(restart);
    items_sent++;
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the board size once the block is idle; the write restarts the search
  task automatic set_board_size(input logic [BoardW-1:0] size);
    drain_results();
    cfg_wdata <= size;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_size = size;
    clear_board_model();
    settings_written++;
  endtask

  // Check each result item against the oldest expectation
  always @(posedge clk) begin : result_checker
    queens_result_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("unexpected result", {rsp_ch.found, rsp_ch.placement}, 0);
      end else begin
        want = awaited_results.pop_front();
        if (rsp_ch.found !== want.found) flag_mismatch("found", rsp_ch.found, want.found);
        if (rsp_ch.placement !== want.placement) begin
          flag_mismatch("placement", rsp_ch.placement, want.placement);
        end
        if (rsp_ch.solutions_so_far !== want.solutions) begin
          flag_mismatch("solutions_so_far", rsp_ch.solutions_so_far, want.solutions);
        end
        if (want.found) placements_seen++;
        else exhausted_seen++;
      end
    end
  end

  // Drive result ready: random stall bursts, or one long hold on request
  initial begin : rsp_ready_driver
    rsp_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
        rsp_ch.ready  <= 1'b1;
        long_hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Default board after reset: first solutions of 8x8, then a restart
  task automatic test_reset_defaults();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
  endtask

  // Tiny, unsolvable, zero and oversized boards; exhaustion and restart
  task automatic test_small_boards();
    set_board_size(4'd1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    set_board_size(4'd2);
    send_request(1'b1);
    set_board_size(4'd3);
    send_request(1'b0);
    set_board_size(4'd0);
    send_request(1'b0);
    send_request(1'b1);
    set_board_size(4'd4);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    set_board_size(4'd15);
    send_request(1'b1);
    send_request(1'b0);
    set_board_size(4'd8);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  // Hold the result side off while requests keep coming, so the block fills
  task automatic test_output_stall();
    int i;
    set_board_size(4'd5);
    gaps_on       = 1'b0;
    stalls_on     = 1'b0;
    long_hold_req = 1'b1;
    for (i = 0; i < 8; i++) send_request(1'b0);
    drain_results();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Phases of random board size, mostly continued searches, some noise
  task automatic test_random_search();
    int unsigned first_item;
    int unsigned sel;
    int unsigned span;
    int unsigned i;
    bit          noisy;
    bit          restart;
    logic [BoardW-1:0] size;
    first_item = items_sent;
    while (items_sent < first_item + RandomItems) begin
      if (items_sent >= first_item + RandomItems - QuietItems) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      // keep most boards small so a phase runs into exhaustion
      sel = $urandom_range(0, 9);
      if (sel < 5) size = 4'($urandom_range(4, 6));
      else if (sel < 7) size = 4'($urandom_range(0, 3));
      else if (sel < 8) size = 4'd7;
      else size = 4'($urandom_range(8, 15));
      set_board_size(size);
      noisy = ($urandom_range(0, 4) == 0);
      span  = $urandom_range(6, 24);
      for (i = 0; i < span; i++) begin
        if (noisy) restart = 1'($urandom_range(0, 1));
        else if (i == 0) restart = 1'($urandom_range(0, 1));
        else restart = ($urandom_range(0, 15) == 0);
        send_request(restart);
      end
    end
  endtask

  initial begin : test_sequence
    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.restart <= 1'b0;
    model_size = BoardReset;
    clear_board_model();
    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_small_boards();
    test_output_stall();
    test_random_search();
    drain_results();

    $display("summary: %0d requests over %0d board-size writes (sizes 0 to 15)",
             items_sent, settings_written);
    $display("summary: %0d placements and %0d exhausted replies checked, one %0d-cycle stall",
             placements_seen, exhausted_seen, LongHoldCycles);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #40_000_000;
    $display("timeout with %0d results outstanding", awaited_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
hdl/nq_pkg.sv
hdl/nq_if.sv
hdl/nq_cell.sv
hdl/n_queens_solution_generator.sv
tb/n_queens_solution_generator_tb.sv
